[rtl/core/acb_pkg.sv]
// ----------------------------------------------------------------------------
// acb_pkg
// Shared widths, constants and request types of the ack bandwidth and
// jitter estimator.
// ----------------------------------------------------------------------------
package acb_pkg;

    // default width of the arrival time
    localparam int TIME_BITS_DEF = 48;

    // field widths
    localparam int SEG_W     = 16;
    localparam int DIVR_W    = 8;
    localparam int THR_W     = 32;
    localparam int GAIN_W    = 9;
    localparam int SEGS_W    = 16;
    localparam int RTT_W     = 32;
    localparam int BIF_W     = 32;
    localparam int SS_W      = 32;
    localparam int BW_W      = 40;
    localparam int JIT_W     = 40;
    localparam int JOUT_W    = 32;
    localparam int FRAC_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    // serial datapath widths
    localparam int ACC_W  = 72;
    localparam int MA_W   = 32;
    localparam int MB_W   = 9;
    localparam int MBX_W  = BW_W + MB_W;
    localparam int QUOT_W = 40;
    localparam int CNT_W  = 6;

    // register reset values
    localparam logic [SEG_W-1:0]  RST_SEGMENT_SIZE = 16'd536;
    localparam logic [DIVR_W-1:0] RST_RECOVERY_DIV = 8'd1;
    localparam logic [THR_W-1:0]  RST_JITTER_THR   = 32'd3000;
    localparam logic [GAIN_W-1:0] RST_JITTER_GAIN  = 9'd51;

    // arithmetic constants
    localparam logic [7:0]        AVG_OLD    = 8'd205;
    localparam logic [7:0]        AVG_NEW    = 8'd51;
    localparam logic [19:0]       USEC_SCALE = 20'd1000000;
    localparam logic [22:0]       BDP_SCALE  = 23'd8000000;
    localparam logic [GAIN_W-1:0] GAIN_ONE   = 9'd256;
    localparam logic [BW_W-1:0]   BW_MAX     = {BW_W{1'b1}};

    // shift-add unit request
    typedef struct packed {
        logic              start;
        logic [BW_W-1:0]   a;
        logic [BW_W-1:0]   b;
        logic [MA_W-1:0]   ma;
        logic [MB_W-1:0]   mb;
    } t_mac_req;

    // divider request
    typedef struct packed {
        logic              start;
        logic [QUOT_W-1:0] num_lo;
        logic [CNT_W-1:0]  steps;
    } t_div_req;

endpackage

[rtl/core/ack_bandwidth_jitter_estimator.sv]
// ----------------------------------------------------------------------------
// ack_bandwidth_jitter_estimator
// Per-acknowledgement bandwidth average, minimum RTT, smoothed jitter and
// slow-start threshold, built on one shift-add unit and one restoring divider.
// ----------------------------------------------------------------------------
// The shift-add unit and the divider run in turn; the shift-add steps follow
//   the highest multiplier bit (up to 20, 8, 9 and 32) and the divider runs
//   40 steps for the bandwidth sample and 32 for the threshold.
// One request at a time: new requests stall until the result is handed to the
//   output register; the next request is taken while a result still waits in
//   that register.
// reset: synchronous, active low; clears estimates and loads register defaults
module ack_bandwidth_jitter_estimator #(
    parameter int TIME_BITS = acb_pkg::TIME_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [TIME_BITS-1:0]            i_now_us,
    input  logic [acb_pkg::SEGS_W-1:0]      i_segments_acked,
    input  logic [acb_pkg::RTT_W-1:0]       i_rtt_us,
    input  logic [acb_pkg::BIF_W-1:0]       i_bytes_in_flight,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [acb_pkg::SS_W-1:0]        o_ssthresh_bytes,
    output logic                            o_estimate_valid,
    output logic                            o_boost_allowed,
    output logic [acb_pkg::BW_W-1:0]        o_bandwidth_bps,
    output logic [acb_pkg::JOUT_W-1:0]      o_smoothed_jitter_us,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [acb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [acb_pkg::CFG_DAT_W-1:0]   i_cfg_data
);

    localparam int DEN_W  = TIME_BITS;
    localparam int CMP_W  = (TIME_BITS > acb_pkg::BW_W) ? TIME_BITS : acb_pkg::BW_W;
    localparam int ACC_W  = acb_pkg::ACC_W;
    localparam int BW_W   = acb_pkg::BW_W;
    localparam int JIT_W  = acb_pkg::JIT_W;
    localparam int SS_W   = acb_pkg::SS_W;
    localparam int RTT_W  = acb_pkg::RTT_W;
    localparam int SEG_W  = acb_pkg::SEG_W;
    localparam int FRAC_W = acb_pkg::FRAC_W;
    localparam int QUOT_W = acb_pkg::QUOT_W;
    localparam int MA_W   = acb_pkg::MA_W;
    localparam int MB_W   = acb_pkg::MB_W;
    localparam int CNT_W  = acb_pkg::CNT_W;
    localparam int BITS_W = 2 * SEG_W + 3;

    typedef enum logic [1:0] {
        CFG_SEGMENT_SIZE = 2'd0,
        CFG_RECOVERY_DIV = 2'd1,
        CFG_JITTER_THR   = 2'd2,
        CFG_JITTER_GAIN  = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NMUL,
        S_BDIV,
        S_BSMP,
        S_AVG,
        S_JIT,
        S_JAVG,
        S_THR,
        S_PMUL,
        S_TDIV,
        S_OUT
    } t_state;

    t_state                          r_state;

    // configuration
    logic [SEG_W-1:0]                r_cfg_seg;
    logic [acb_pkg::DIVR_W-1:0]      r_cfg_div;
    logic [acb_pkg::THR_W-1:0]       r_cfg_thr;
    logic [acb_pkg::GAIN_W-1:0]      r_cfg_gain;

    // estimator state
    logic [TIME_BITS-1:0]            r_last;
    logic                            r_seen_first;
    logic [BW_W-1:0]                 r_bw;
    logic [RTT_W-1:0]                r_min;
    logic [JIT_W-1:0]                r_jit;
    logic                            r_jseen;

    // captured request and working values
    logic [RTT_W-1:0]                r_rtt;
    logic [acb_pkg::BIF_W-1:0]       r_bif;
    logic [BW_W-1:0]                 r_sample;
    logic [SS_W-1:0]                 r_ss;
    logic                            r_est;

    // unit requests
    acb_pkg::t_mac_req               r_mac;
    acb_pkg::t_div_req               r_div;
    logic [DEN_W-1:0]                r_div_rem0;
    logic [DEN_W-1:0]                r_div_den;

    // result register
    logic                            r_out_valid;
    logic [SS_W-1:0]                 r_o_ss;
    logic                            r_o_est;
    logic                            r_o_boost;
    logic [BW_W-1:0]                 r_o_bw;
    logic [acb_pkg::JOUT_W-1:0]      r_o_jit;

    // unit results
    logic                            w_mac_done;
    logic [ACC_W-1:0]                w_mac_acc;
    logic                            w_div_done;
    logic [QUOT_W-1:0]               w_div_quot;

    // combinational helpers
    logic                            w_accept;
    logic                            w_out_free;
    logic [SEG_W:0]                  w_two_seg;
    logic [2*SEG_W-1:0]              w_segbytes;
    logic [TIME_BITS-1:0]            w_dt;
    logic                            w_has_sample;
    logic [RTT_W-1:0]                n_min;
    logic [JIT_W-1:0]                n_jq;
    logic [acb_pkg::GAIN_W-1:0]      w_gain;
    logic [acb_pkg::DIVR_W-1:0]      w_div_eff;
    logic [30:0]                     w_bdp_den;
    logic [SS_W-1:0]                 w_ss_bif;
    logic [SS_W-1:0]                 w_ss_quot;
    logic                            w_bw_sat;
    logic                            w_ss_sat;
    logic                            w_boost;

    // serial shift-add unit
    acb_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_mac),
        .o_done  (w_mac_done),
        .o_acc   (w_mac_acc)
    );

    // restoring divider
    acb_div #(
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div),
        .i_rem0  (r_div_rem0),
        .i_den   (r_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    // handshake
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // request-side arithmetic
    always_comb begin
        w_two_seg    = {r_cfg_seg, 1'b0};
        w_segbytes   = i_segments_acked * r_cfg_seg;
        w_dt         = i_now_us - r_last;
        w_has_sample = r_seen_first && (i_segments_acked != '0) && (i_now_us > r_last);
    end

    // rtt minimum, jitter sample and gain clamp
    always_comb begin
        n_min  = (r_rtt < r_min) ? r_rtt : r_min;
        n_jq   = {r_rtt - n_min, {FRAC_W{1'b0}}};
        w_gain = (r_cfg_gain > acb_pkg::GAIN_ONE) ? acb_pkg::GAIN_ONE : r_cfg_gain;
    end

    // threshold terms
    always_comb begin
        w_div_eff = (r_cfg_div == '0) ? acb_pkg::DIVR_W'(1) : r_cfg_div;
        w_bdp_den = acb_pkg::BDP_SCALE * w_div_eff;
        w_ss_bif  = (32'(r_bif[acb_pkg::BIF_W-1:1]) < 32'(w_two_seg)) ?
                    32'(w_two_seg) : 32'(r_bif[acb_pkg::BIF_W-1:1]);
        w_ss_quot = (w_div_quot[SS_W-1:0] < 32'(w_two_seg)) ?
                    32'(w_two_seg) : w_div_quot[SS_W-1:0];
        w_bw_sat  = CMP_W'(w_mac_acc[ACC_W-1:QUOT_W]) >= CMP_W'(r_div_den);
        w_ss_sat  = CMP_W'(w_mac_acc[ACC_W-1:SS_W]) >= CMP_W'(r_div_den);
        w_boost   = !r_jseen || (r_jit <= {r_cfg_thr, {FRAC_W{1'b0}}});
    end

    // sequencer, estimator state, configuration and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cfg_seg    <= acb_pkg::RST_SEGMENT_SIZE;
            r_cfg_div    <= acb_pkg::RST_RECOVERY_DIV;
            r_cfg_thr    <= acb_pkg::RST_JITTER_THR;
            r_cfg_gain   <= acb_pkg::RST_JITTER_GAIN;
            r_last       <= '0;
            r_seen_first <= 1'b0;
            r_bw         <= '0;
            r_min        <= '1;
            r_jit        <= '0;
            r_jseen      <= 1'b0;
            r_mac.start  <= 1'b0;
            r_div.start  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_mac.start <= 1'b0;
            r_div.start <= 1'b0;

            // configuration writes
            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_SEGMENT_SIZE: r_cfg_seg  <= i_cfg_data[SEG_W-1:0];
                    CFG_RECOVERY_DIV: r_cfg_div  <= i_cfg_data[acb_pkg::DIVR_W-1:0];
                    CFG_JITTER_THR:   r_cfg_thr  <= i_cfg_data[acb_pkg::THR_W-1:0];
                    CFG_JITTER_GAIN:  r_cfg_gain <= i_cfg_data[acb_pkg::GAIN_W-1:0];
                    default: ;
                endcase
            end

            // result taken downstream
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                // take a request, start the acked-bits scaling if a sample is due
                S_IDLE: begin
                    if (w_accept) begin
                        r_rtt        <= i_rtt_us;
                        r_bif        <= i_bytes_in_flight;
                        r_last       <= i_now_us;
                        r_seen_first <= 1'b1;
                        r_div_den    <= w_dt;
                        if (w_has_sample) begin
                            r_mac.start <= 1'b1;
                            r_mac.a     <= BW_W'({w_segbytes, 3'b000});
                            r_mac.ma    <= MA_W'(acb_pkg::USEC_SCALE);
                            r_mac.b     <= '0;
                            r_mac.mb    <= '0;
                            r_state     <= S_NMUL;
                        end else begin
                            r_state <= S_JIT;
                        end
                    end
                end
                // acked bits times 1e6 ready, divide by elapsed time or saturate the sample
                S_NMUL: begin
                    if (w_mac_done) begin
                        if (w_bw_sat) begin
                            r_sample <= acb_pkg::BW_MAX;
                            r_state  <= S_BSMP;
                        end else begin
                            r_div.start  <= 1'b1;
                            r_div.num_lo <= w_mac_acc[QUOT_W-1:0];
                            r_div.steps  <= CNT_W'(QUOT_W);
                            r_div_rem0   <= DEN_W'(w_mac_acc[ACC_W-1:QUOT_W]);
                            r_state      <= S_BDIV;
                        end
                    end
                end
                S_BDIV: begin
                    if (w_div_done) begin
                        r_sample <= w_div_quot;
                        r_state  <= S_BSMP;
                    end
                end
                // fold the sample into the average, or take it as the first value
                S_BSMP: begin
                    if (r_bw == '0) begin
                        r_bw    <= r_sample;
                        r_state <= S_JIT;
                    end else begin
                        r_mac.start <= 1'b1;
                        r_mac.a     <= r_bw;
                        r_mac.ma    <= MA_W'(acb_pkg::AVG_OLD);
                        r_mac.b     <= r_sample;
                        r_mac.mb    <= MB_W'(acb_pkg::AVG_NEW);
                        r_state     <= S_AVG;
                    end
                end
                S_AVG: begin
                    if (w_mac_done) begin
                        r_bw    <= w_mac_acc[BW_W+FRAC_W-1:FRAC_W];
                        r_state <= S_JIT;
                    end
                end
                // rtt sample: minimum and jitter
                S_JIT: begin
                    r_state <= S_THR;
                    if (r_rtt != '0) begin
                        r_min <= n_min;
                        if (n_min != '1) begin
                            if (!r_jseen) begin
                                r_jit   <= n_jq;
                                r_jseen <= 1'b1;
                            end else begin
                                r_mac.start <= 1'b1;
                                r_mac.a     <= r_jit;
                                r_mac.ma    <= MA_W'(acb_pkg::GAIN_ONE - w_gain);
                                r_mac.b     <= n_jq;
                                r_mac.mb    <= w_gain;
                                r_state     <= S_JAVG;
                            end
                        end
                    end
                end
                S_JAVG: begin
                    if (w_mac_done) begin
                        r_jit   <= w_mac_acc[JIT_W+FRAC_W-1:FRAC_W];
                        r_state <= S_THR;
                    end
                end
                // threshold: bandwidth-delay product or half the flight size
                S_THR: begin
                    r_div_den <= DEN_W'(w_bdp_den);
                    if ((r_bw != '0) && (r_min != '1)) begin
                        r_est       <= 1'b1;
                        r_mac.start <= 1'b1;
                        r_mac.a     <= r_bw;
                        r_mac.ma    <= r_min;
                        r_mac.b     <= '0;
                        r_mac.mb    <= '0;
                        r_state     <= S_PMUL;
                    end else begin
                        r_est   <= 1'b0;
                        r_ss    <= w_ss_bif;
                        r_state <= S_OUT;
                    end
                end
                S_PMUL: begin
                    if (w_mac_done) begin
                        if (w_ss_sat) begin
                            r_ss    <= '1;
                            r_state <= S_OUT;
                        end else begin
                            r_div.start  <= 1'b1;
                            r_div.num_lo <= {w_mac_acc[SS_W-1:0], {(QUOT_W-SS_W){1'b0}}};
                            r_div.steps  <= CNT_W'(SS_W);
                            r_div_rem0   <= DEN_W'(w_mac_acc[ACC_W-1:SS_W]);
                            r_state      <= S_TDIV;
                        end
                    end
                end
                S_TDIV: begin
                    if (w_div_done) begin
                        r_ss    <= w_ss_quot;
                        r_state <= S_OUT;
                    end
                end
                // hand the result to the output register
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_ss      <= r_ss;
                        r_o_est     <= r_est;
                        r_o_boost   <= w_boost;
                        r_o_bw      <= r_bw;
                        r_o_jit     <= r_jit[JIT_W-1:FRAC_W];
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_ssthresh_bytes     = r_o_ss;
    assign o_estimate_valid     = r_o_est;
    assign o_boost_allowed      = r_o_boost;
    assign o_bandwidth_bps      = r_o_bw;
    assign o_smoothed_jitter_us = r_o_jit;

    // one request in flight at a time
    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted while another is in flight");

    // a result only comes out of the hand-off state
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_OUT))
        else $error("result raised outside the hand-off state");

    // a valid estimate needs a nonzero bandwidth
    a_est_has_bw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_estimate_valid) |-> (o_bandwidth_bps != '0))
        else $error("estimate flagged valid with zero bandwidth");

    // threshold never below two segments
    a_ss_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_ssthresh_bytes >= 32'(w_two_seg)))
        else $error("threshold below two segments");

    // the multiplier and divider never finish together
    a_units_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mac_done && w_div_done))
        else $error("multiplier and divider finished in the same cycle");

endmodule

[rtl/core/acb_mac.sv]
// ----------------------------------------------------------------------------
// acb_mac
// Bit-serial shift-add multiplier: acc = a * ma + b * mb, one multiplier
// bit of each operand per cycle, finishing when both multipliers run out.
// ----------------------------------------------------------------------------
module acb_mac (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  acb_pkg::t_mac_req           i_req,
    output logic                        o_done,
    output logic [acb_pkg::ACC_W-1:0]   o_acc
);

    localparam int ACC_W = acb_pkg::ACC_W;
    localparam int MBX_W = acb_pkg::MBX_W;
    localparam int MA_W  = acb_pkg::MA_W;
    localparam int MB_W  = acb_pkg::MB_W;

    logic              r_busy;
    logic              r_done;
    logic [ACC_W-1:0]  r_a;
    logic [MBX_W-1:0]  r_b;
    logic [MA_W-1:0]   r_ma;
    logic [MB_W-1:0]   r_mb;
    logic [ACC_W-1:0]  r_acc;
    logic [ACC_W-1:0]  n_acc;
    logic              w_last;

    // partial product add for the current multiplier bits
    always_comb begin
        n_acc = r_acc + (r_ma[0] ? r_a : '0) + (r_mb[0] ? ACC_W'(r_b) : '0);
    end

    assign w_last = (r_ma == '0) && (r_mb == '0);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && w_last) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // operand shift registers and accumulator
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= ACC_W'(i_req.a);
            r_b   <= MBX_W'(i_req.b);
            r_ma  <= i_req.ma;
            r_mb  <= i_req.mb;
            r_acc <= '0;
        end else if (r_busy && !w_last) begin
            r_acc <= n_acc;
            r_a   <= {r_a[ACC_W-2:0], 1'b0};
            r_b   <= {r_b[MBX_W-2:0], 1'b0};
            r_ma  <= {1'b0, r_ma[MA_W-1:1]};
            r_mb  <= {1'b0, r_mb[MB_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;

endmodule

[rtl/core/acb_div.sv]
// ----------------------------------------------------------------------------
// acb_div
// Restoring divider, one quotient bit per cycle. The dividend's low part
// shifts out of the top of a register while quotient bits shift in below.
// The divisor is held stable by the requester for the whole run.
// ----------------------------------------------------------------------------
module acb_div #(
    parameter int DEN_W = acb_pkg::TIME_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  acb_pkg::t_div_req            i_req,
    input  logic [DEN_W-1:0]             i_rem0,
    input  logic [DEN_W-1:0]             i_den,
    output logic                         o_done,
    output logic [acb_pkg::QUOT_W-1:0]   o_quot
);

    localparam int QUOT_W = acb_pkg::QUOT_W;
    localparam int CNT_W  = acb_pkg::CNT_W;

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DEN_W-1:0]  r_rem;
    logic [QUOT_W-1:0] r_dq;
    logic [DEN_W:0]    w_trial;
    logic [DEN_W:0]    w_diff;
    logic              w_ge;
    logic [DEN_W-1:0]  n_rem;
    logic [QUOT_W-1:0] n_dq;

    // one trial subtraction
    always_comb begin
        w_trial = {r_rem, r_dq[QUOT_W-1]};
        w_ge    = (w_trial >= {1'b0, i_den});
        w_diff  = w_trial - {1'b0, i_den};
        n_rem   = w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
        n_dq    = {r_dq[QUOT_W-2:0], w_ge};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and dividend/quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_rem0;
            r_dq  <= i_req.num_lo;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dq  <= n_dq;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_dq;

endmodule
